### hw/rtl/c8x_pkg.sv
// Shared types, opcodes and constants for the CHIP-8 register execute unit.
package c8x_pkg;

  // Field widths
  localparam int PC_W   = 12;
  localparam int INS_W  = 16;
  localparam int RND_W  = 8;
  localparam int VAL_W  = 8;
  localparam int REG_CNT = 16;
  localparam int RIDX_W = 4;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Defaults
  localparam int                STACK_DEPTH_DEF = 16;
  localparam logic [PC_W-1:0]   START_RESET     = 12'h200;

  // Register map: word index taken from paddr[2]
  localparam logic REG_IDX_START = 1'b0;

  // Flag register index
  localparam logic [RIDX_W-1:0] FLAG_REG = 4'hF;

  // Major opcodes (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // ALU sub-operations (low nibble of 8XYn)
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Full-word system instructions
  localparam logic [INS_W-1:0] INS_CLS = 16'h00E0;
  localparam logic [INS_W-1:0] INS_RET = 16'h00EE;

  // Key opcodes (EXnn)
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  // Misc opcodes (FXnn), reported as not implemented
  localparam logic [7:0] F_LD_DT  = 8'h07;
  localparam logic [7:0] F_LD_K   = 8'h0A;
  localparam logic [7:0] F_SET_DT = 8'h15;
  localparam logic [7:0] F_SET_ST = 8'h18;
  localparam logic [7:0] F_ADD_I  = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STORE  = 8'h55;
  localparam logic [7:0] F_LOAD   = 8'h65;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NOT_IMPL  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  // One executed result
  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    status_t           status;
    logic              reg_written;
    logic [RIDX_W-1:0] reg_index;
    logic [VAL_W-1:0]  reg_value;
    logic              flag_written;
    logic              flag_value;
    logic [PC_W-1:0]   index_value;
  } exec_res_t;

  // Stack request from the execute logic
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [PC_W-1:0] push_data;
  } stk_ctl_t;

  // Stack status toward the execute logic
  typedef struct packed {
    logic            empty;
    logic            full;
    logic [PC_W-1:0] top;
  } stk_stat_t;

  // Register file write port group
  typedef struct packed {
    logic              wr_en;
    logic [RIDX_W-1:0] wr_idx;
    logic [VAL_W-1:0]  wr_data;
    logic              fw_en;
    logic              fw_data;
  } rf_wr_t;

endpackage

### hw/rtl/c8x_regfile.sv
// General register file V0..VF with registered reads and same-cycle write forwarding.
module c8x_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  c8x_pkg::rf_wr_t               wr,
  input  logic                          rd_en,
  input  logic [c8x_pkg::RIDX_W-1:0]    rd_x,
  input  logic [c8x_pkg::RIDX_W-1:0]    rd_y,
  output logic [c8x_pkg::VAL_W-1:0]     vx,
  output logic [c8x_pkg::VAL_W-1:0]     vy,
  output logic [c8x_pkg::VAL_W-1:0]     v0
);

  logic [c8x_pkg::VAL_W-1:0] regs_r   [c8x_pkg::REG_CNT];
  logic [c8x_pkg::VAL_W-1:0] regs_nxt [c8x_pkg::REG_CNT];
  logic [c8x_pkg::VAL_W-1:0] vx_r, vy_r, v0_r;

  // Apply VX write, then VF flag write on top (flag wins for X = F)
  always_comb begin
    for (int i = 0; i < c8x_pkg::REG_CNT; i++) begin
      regs_nxt[i] = regs_r[i];
      if (wr.fw_en && (c8x_pkg::RIDX_W'(i) == c8x_pkg::FLAG_REG)) begin
        regs_nxt[i] = {{(c8x_pkg::VAL_W-1){1'b0}}, wr.fw_data};
      end else if (wr.wr_en && (wr.wr_idx == c8x_pkg::RIDX_W'(i))) begin
        regs_nxt[i] = wr.wr_data;
      end
    end
  end

  // Hold register contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < c8x_pkg::REG_CNT; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Capture operands for the accepted item, seeing this cycle's writes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vx_r <= regs_nxt[rd_x];
      vy_r <= regs_nxt[rd_y];
      v0_r <= regs_nxt[0];
    end
  end

  assign vx = vx_r;
  assign vy = vy_r;
  assign v0 = v0_r;

endmodule

### hw/rtl/c8x_stack.sv
// Return address stack: memory, depth counter and registered top-of-stack read.
module c8x_stack #(
  parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  c8x_pkg::stk_ctl_t    ctl,
  input  logic                 rd_en,
  output c8x_pkg::stk_stat_t   stat
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [c8x_pkg::PC_W-1:0] mem [STACK_DEPTH];
  logic [DW-1:0]            depth_r, depth_nxt, rd_dep;
  logic [AW-1:0]            rd_addr;
  logic [c8x_pkg::PC_W-1:0] top_rd_r, fwd_data_r;
  logic                     fwd_r;

  // Next depth and address of the next top entry
  always_comb begin
    depth_nxt = depth_r;
    if (ctl.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (ctl.pop) begin
      depth_nxt = depth_r - DW'(1);
    end
    rd_dep  = depth_nxt - DW'(1);
    rd_addr = rd_dep[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Write pushed return address
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[depth_r[AW-1:0]] <= ctl.push_data;
    end
  end

  // Read next top for the accepted item; forward a push of this cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_rd_r   <= mem[rd_addr];
      fwd_data_r <= ctl.push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= ctl.push;
    end
  end

  assign stat.empty = (depth_r == '0);
  assign stat.full  = (depth_r == DW'(STACK_DEPTH));
  assign stat.top   = fwd_r ? fwd_data_r : top_rd_r;

endmodule

### hw/rtl/c8x_exec.sv
// Instruction decode and execute: ALU, loads, random, index, skips, jumps, call/return and status.
module c8x_exec (
  input  logic [c8x_pkg::INS_W-1:0]  ins,
  input  logic [c8x_pkg::RND_W-1:0]  rnd,
  input  logic [c8x_pkg::VAL_W-1:0]  vx,
  input  logic [c8x_pkg::VAL_W-1:0]  vy,
  input  logic [c8x_pkg::VAL_W-1:0]  v0,
  input  logic [c8x_pkg::PC_W-1:0]   pc,
  input  logic [c8x_pkg::PC_W-1:0]   index,
  input  c8x_pkg::stk_stat_t         stk,
  output c8x_pkg::exec_res_t         res,
  output c8x_pkg::stk_ctl_t          ctl
);

  logic [3:0]                  op, x, n;
  logic [7:0]                  nn;
  logic [c8x_pkg::PC_W-1:0]    nnn, pc2, pc4, jump_v0, next;
  logic [c8x_pkg::VAL_W:0]     sum_w;
  logic [c8x_pkg::VAL_W-1:0]   val;
  logic                        wr, fw, flag, skip;
  c8x_pkg::status_t            status;

  assign op  = ins[15:12];
  assign x   = ins[11:8];
  assign n   = ins[3:0];
  assign nn  = ins[7:0];
  assign nnn = ins[11:0];

  assign pc2     = pc + 12'd2;
  assign pc4     = pc + 12'd4;
  assign jump_v0 = {4'b0, v0} + nnn;
  assign sum_w   = {1'b0, vx} + {1'b0, vy};

  // Decode and execute
  always_comb begin
    next   = pc2;
    status = c8x_pkg::ST_DONE;
    wr     = 1'b0;
    fw     = 1'b0;
    val    = '0;
    flag   = 1'b0;
    skip   = 1'b0;
    ctl.push      = 1'b0;
    ctl.pop       = 1'b0;
    ctl.push_data = pc2;
    res.index_value = index;

    unique case (op)
      c8x_pkg::OP_SYS: begin
        if (ins == c8x_pkg::INS_CLS) begin
          status = c8x_pkg::ST_NOT_IMPL;
        end else if (ins == c8x_pkg::INS_RET) begin
          if (stk.empty) begin
            status = c8x_pkg::ST_UNDERFLOW;
          end else begin
            ctl.pop = 1'b1;
            next    = stk.top;
          end
        end else begin
          status = c8x_pkg::ST_UNKNOWN;
        end
      end
      c8x_pkg::OP_JP: next = nnn;
      c8x_pkg::OP_CALL: begin
        if (stk.full) begin
          status = c8x_pkg::ST_OVERFLOW;
        end else begin
          ctl.push = 1'b1;
          next     = nnn;
        end
      end
      c8x_pkg::OP_SEI:  skip = (vx == nn);
      c8x_pkg::OP_SNEI: skip = (vx != nn);
      c8x_pkg::OP_SER: begin
        if (n == 4'h0) skip = (vx == vy);
        else status = c8x_pkg::ST_UNKNOWN;
      end
      c8x_pkg::OP_LDI: begin
        wr  = 1'b1;
        val = nn;
      end
      c8x_pkg::OP_ADDI: begin
        wr  = 1'b1;
        val = vx + nn;
      end
      c8x_pkg::OP_ALU: begin
        case (n)
          c8x_pkg::ALU_MOV: begin wr = 1'b1; val = vy; end
          c8x_pkg::ALU_OR:  begin wr = 1'b1; val = vx | vy; end
          c8x_pkg::ALU_AND: begin wr = 1'b1; val = vx & vy; end
          c8x_pkg::ALU_XOR: begin wr = 1'b1; val = vx ^ vy; end
          c8x_pkg::ALU_ADD: begin
            wr = 1'b1; fw = 1'b1;
            val  = sum_w[c8x_pkg::VAL_W-1:0];
            flag = sum_w[c8x_pkg::VAL_W];
          end
          c8x_pkg::ALU_SUB: begin
            wr = 1'b1; fw = 1'b1;
            val  = vx - vy;
            flag = (vx >= vy);
          end
          c8x_pkg::ALU_SHR: begin
            wr = 1'b1; fw = 1'b1;
            val  = {1'b0, vy[c8x_pkg::VAL_W-1:1]};
            flag = vy[0];
          end
          c8x_pkg::ALU_SUBN: begin
            wr = 1'b1; fw = 1'b1;
            val  = vy - vx;
            flag = (vy >= vx);
          end
          c8x_pkg::ALU_SHL: begin
            wr = 1'b1; fw = 1'b1;
            val  = {vy[c8x_pkg::VAL_W-2:0], 1'b0};
            flag = vy[c8x_pkg::VAL_W-1];
          end
          default: status = c8x_pkg::ST_UNKNOWN;
        endcase
      end
      c8x_pkg::OP_SNER: begin
        if (n == 4'h0) skip = (vx != vy);
        else status = c8x_pkg::ST_UNKNOWN;
      end
      c8x_pkg::OP_LDIX: res.index_value = nnn;
      c8x_pkg::OP_JPV0: next = jump_v0;
      c8x_pkg::OP_RND: begin
        wr  = 1'b1;
        val = rnd & nn;
      end
      c8x_pkg::OP_DRW: status = c8x_pkg::ST_NOT_IMPL;
      c8x_pkg::OP_KEY: begin
        if (nn == c8x_pkg::KEY_SKP || nn == c8x_pkg::KEY_SKNP) begin
          status = c8x_pkg::ST_NOT_IMPL;
        end else begin
          status = c8x_pkg::ST_UNKNOWN;
        end
      end
      c8x_pkg::OP_MISC: begin
        case (nn) inside
          c8x_pkg::F_LD_DT, c8x_pkg::F_LD_K, c8x_pkg::F_SET_DT,
          c8x_pkg::F_SET_ST, c8x_pkg::F_ADD_I, c8x_pkg::F_FONT,
          c8x_pkg::F_BCD, c8x_pkg::F_STORE, c8x_pkg::F_LOAD:
            status = c8x_pkg::ST_NOT_IMPL;
          default: status = c8x_pkg::ST_UNKNOWN;
        endcase
      end
      default: status = c8x_pkg::ST_UNKNOWN;
    endcase

    // Taken skip jumps over the next instruction
    if (skip) next = pc4;

    res.next_pc      = next;
    res.status       = status;
    res.reg_written  = wr;
    res.reg_index    = wr ? x : '0;
    res.reg_value    = wr ? val : '0;
    res.flag_written = fw;
    res.flag_value   = fw ? flag : 1'b0;
  end

endmodule

### hw/rtl/chip8_register_execute_unit.sv
// Top level of the CHIP-8 register execute unit: channels, state and pipeline control.
//
// Usage: each input item carries one 16-bit instruction and a random byte; the
// unit executes it against V0..VF, the index register, the PC and the return
// stack, and emits exactly one result item (next PC, status, register and
// flag writes, index value).
// Pipeline: an input register holds the accepted item while the register file
// and stack top are read; the item executes once the output register can take
// it, and its result is loaded into the output register. Throughput is one item
// per cycle while out_tready is high, set by the single execute stage whose
// state writeback completes in the same cycle.
// Stalls: while out_tready is low the output register holds its item, the
// input register holds the next one, and in_tready drops once both are full.
// Reset (rst_n low, synchronous): registers and index clear, the stack empties,
// the PC and start_address return to 0x200, and both channels go empty.
// Configuration: start_address at byte address 0; writing it also loads the PC.
// Write it only while no item is in flight.
module chip8_register_execute_unit #(
  parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: instruction_word[15:0], random_byte[23:16]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [c8x_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: next_pc[11:0], status[14:12], reg_written[15], reg_index[19:16],
  // reg_value[27:20], flag_written[28], flag_value[29], index_value[41:30], zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [c8x_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [c8x_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [c8x_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [c8x_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  logic                                in_accept, exec_fire, cfg_wr_start;
  logic                                in_valid_r, out_valid_r;
  logic [c8x_pkg::INS_W-1:0]           ins_r;
  logic [c8x_pkg::RND_W-1:0]           rnd_r;
  logic [c8x_pkg::PC_W-1:0]            pc_r, index_r, start_r;
  logic [c8x_pkg::PC_W-1:0]            pc_nxt, index_nxt;
  logic [c8x_pkg::OUT_TDATA_W-1:0]     out_data_r;
  logic [c8x_pkg::VAL_W-1:0]           vx, vy, v0;
  c8x_pkg::exec_res_t                  res;
  c8x_pkg::stk_ctl_t                   ctl, stk_ctl;
  c8x_pkg::stk_stat_t                  stk_stat;
  c8x_pkg::rf_wr_t                     rf_wr;

  // Handshakes
  assign in_accept = in_tvalid & in_tready;
  assign exec_fire = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | exec_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ins_r <= in_tdata[15:0];
      rnd_r <= in_tdata[23:16];
    end
  end

  // Register file and stack, both committed only when the item executes
  assign rf_wr.wr_en   = exec_fire & res.reg_written;
  assign rf_wr.wr_idx  = res.reg_index;
  assign rf_wr.wr_data = res.reg_value;
  assign rf_wr.fw_en   = exec_fire & res.flag_written;
  assign rf_wr.fw_data = res.flag_value;

  assign stk_ctl.push      = exec_fire & ctl.push;
  assign stk_ctl.pop       = exec_fire & ctl.pop;
  assign stk_ctl.push_data = ctl.push_data;

  c8x_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rf_wr),
    .rd_en (in_accept),
    .rd_x  (in_tdata[11:8]),
    .rd_y  (in_tdata[7:4]),
    .vx    (vx),
    .vy    (vy),
    .v0    (v0)
  );

  c8x_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .rd_en (in_accept),
    .stat  (stk_stat)
  );

  c8x_exec u_exec (
    .ins   (ins_r),
    .rnd   (rnd_r),
    .vx    (vx),
    .vy    (vy),
    .v0    (v0),
    .pc    (pc_r),
    .index (index_r),
    .stk   (stk_stat),
    .res   (res),
    .ctl   (ctl)
  );

  // Configuration write decode
  assign cfg_pready   = 1'b1;
  assign cfg_wr_start = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                        (cfg_paddr[2] == c8x_pkg::REG_IDX_START);
  assign cfg_prdata   = (cfg_paddr[2] == c8x_pkg::REG_IDX_START) ?
                        {{(c8x_pkg::CFG_DW-c8x_pkg::PC_W){1'b0}}, start_r} : '0;

  // PC and index next values
  always_comb begin
    pc_nxt    = pc_r;
    index_nxt = index_r;
    if (cfg_wr_start) begin
      pc_nxt = cfg_pwdata[c8x_pkg::PC_W-1:0];
    end else if (exec_fire) begin
      pc_nxt    = res.next_pc;
      index_nxt = res.index_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= c8x_pkg::START_RESET;
      pc_r    <= c8x_pkg::START_RESET;
      index_r <= '0;
    end else begin
      if (cfg_wr_start) begin
        start_r <= cfg_pwdata[c8x_pkg::PC_W-1:0];
      end
      pc_r    <= pc_nxt;
      index_r <= index_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= {6'b0, res.index_value, res.flag_value, res.flag_written,
                     res.reg_value, res.reg_index, res.reg_written,
                     res.status, res.next_pc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // An executed item always shows up in the output register
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("executed item did not reach the output register");

  // A held input item keeps its instruction until it executes
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !exec_fire) |=> (in_valid_r && $stable(ins_r)))
    else $error("pending item lost or changed");

  // A committed call leaves the stack non-empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.push |=> !stk_stat.empty)
    else $error("stack empty after push");

  // Overflow and underflow are only reported against a full or empty stack
  a_stk_status: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |-> ((res.status != c8x_pkg::ST_OVERFLOW || stk_stat.full) &&
                   (res.status != c8x_pkg::ST_UNDERFLOW || stk_stat.empty)))
    else $error("stack status does not match stack depth");
`endif

endmodule

### sim/tb_chip8_register_execute_unit.sv
// Self-checking stream testbench for the CHIP-8 register execute unit with its own predictor.
`timescale 1ns / 1ps

module tb_chip8_register_execute_unit;
  import c8x_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [CFG_AW-1:0] START_ADDR_OFS = {REG_IDX_START, 2'b00};
  // 8XYn sub-operation with no meaning, used to reach the unknown-opcode path
  localparam logic [3:0] ALU_UNUSED = 4'h8;

  typedef struct {
    logic [INS_W-1:0] ins;
    logic [RND_W-1:0] rnd;
  } instr_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // in_tdata: instruction_word[15:0], random_byte[23:16]
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // out_tdata: next_pc[11:0], status[14:12], reg_written[15], reg_index[19:16],
  // reg_value[27:20], flag_written[28], flag_value[29], index_value[41:30], zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Predictor state
  logic [VAL_W-1:0] v_reg [REG_CNT];
  logic [PC_W-1:0]  i_reg;
  logic [PC_W-1:0]  pc_reg;
  logic [PC_W-1:0]  call_stack [STACK_DEPTH_DEF];
  int               call_depth;

  instr_item_t instr_q[$];
  exec_res_t   exec_result_q[$];
  instr_item_t send_item;

  int errors = 0;
  int cycle_cnt = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  chip8_register_execute_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Execute one instruction against the predicted machine state
  function automatic exec_res_t execute_instr(logic [INS_W-1:0] ins, logic [RND_W-1:0] rnd);
    exec_res_t        r;
    logic [3:0]       op;
    logic [3:0]       x;
    logic [3:0]       y;
    logic [3:0]       n;
    logic [7:0]       nn;
    logic [PC_W-1:0]  nnn;
    logic [VAL_W-1:0] vx;
    logic [VAL_W-1:0] vy;
    logic [VAL_W-1:0] val;
    logic [PC_W-1:0]  pc2;
    logic [PC_W-1:0]  nxt;
    logic [8:0]       sum;
    logic             wr;
    logic             fw;
    logic             flg;
    logic             skip;
    status_t          st;
    op = ins[15:12];
    x = ins[11:8];
    y = ins[7:4];
    n = ins[3:0];
    nn = ins[7:0];
    nnn = ins[11:0];
    vx = v_reg[x];
    vy = v_reg[y];
    pc2 = pc_reg + 12'd2;
    nxt = pc2;
    st = ST_DONE;
    wr = 1'b0;
    fw = 1'b0;
    val = '0;
    flg = 1'b0;
    skip = 1'b0;
    case (op)
      OP_SYS: begin
        if (ins == INS_CLS) begin
          st = ST_NOT_IMPL;
        end else if (ins == INS_RET) begin
          if (call_depth == 0) begin
            st = ST_UNDERFLOW;
          end else begin
            call_depth--;
            nxt = call_stack[call_depth];
          end
        end else begin
          st = ST_UNKNOWN;
        end
      end
      OP_JP: nxt = nnn;
      OP_CALL: begin
        if (call_depth >= STACK_DEPTH_DEF) begin
          st = ST_OVERFLOW;
        end else begin
          call_stack[call_depth] = pc2;
          call_depth++;
          nxt = nnn;
        end
      end
      OP_SEI:  skip = (vx == nn);
      OP_SNEI: skip = (vx != nn);
      OP_SER: begin
        if (n == 4'h0) skip = (vx == vy);
        else st = ST_UNKNOWN;
      end
      OP_LDI: begin
        wr = 1'b1;
        val = nn;
      end
      OP_ADDI: begin
        wr = 1'b1;
        val = vx + nn;
      end
      OP_ALU: begin
        wr = 1'b1;
        case (n)
          ALU_MOV: val = vy;
          ALU_OR:  val = vx | vy;
          ALU_AND: val = vx & vy;
          ALU_XOR: val = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            val = sum[7:0];
            flg = sum[8];
            fw = 1'b1;
          end
          ALU_SUB: begin
            val = vx - vy;
            flg = (vx >= vy);
            fw = 1'b1;
          end
          ALU_SHR: begin
            val = vy >> 1;
            flg = vy[0];
            fw = 1'b1;
          end
          ALU_SUBN: begin
            val = vy - vx;
            flg = (vy >= vx);
            fw = 1'b1;
          end
          ALU_SHL: begin
            val = vy << 1;
            flg = vy[7];
            fw = 1'b1;
          end
          default: begin
            wr = 1'b0;
            st = ST_UNKNOWN;
          end
        endcase
      end
      OP_SNER: begin
        if (n == 4'h0) skip = (vx != vy);
        else st = ST_UNKNOWN;
      end
      OP_LDIX: i_reg = nnn;
      OP_JPV0: nxt = PC_W'(v_reg[0]) + nnn;
      OP_RND: begin
        wr = 1'b1;
        val = rnd & nn;
      end
      OP_DRW: st = ST_NOT_IMPL;
      OP_KEY: st = (nn == KEY_SKP || nn == KEY_SKNP) ? ST_NOT_IMPL : ST_UNKNOWN;
      default: begin
        case (nn)
          F_LD_DT, F_LD_K, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT, F_BCD, F_STORE, F_LOAD:
            st = ST_NOT_IMPL;
          default: st = ST_UNKNOWN;
        endcase
      end
    endcase
    if (skip) nxt = pc_reg + 12'd4;
    // A flag write to VF wins over the ALU result for the same register
    if (wr) v_reg[x] = val;
    if (fw) v_reg[FLAG_REG] = {7'b0, flg};
    pc_reg = nxt;
    r.next_pc = nxt;
    r.status = st;
    r.reg_written = wr;
    r.reg_index = wr ? x : '0;
    r.reg_value = wr ? val : '0;
    r.flag_written = fw;
    r.flag_value = fw ? flg : 1'b0;
    r.index_value = i_reg;
    return r;
  endfunction

  function automatic logic [INS_W-1:0] enc_xnn(logic [3:0] op, logic [3:0] x, logic [7:0] nn);
    return {op, x, nn};
  endfunction

  function automatic logic [INS_W-1:0] enc_xyn(logic [3:0] op, logic [3:0] x, logic [3:0] y,
                                               logic [3:0] n);
    return {op, x, y, n};
  endfunction

  function automatic void add_instr(logic [INS_W-1:0] w);
    instr_item_t it;
    it.ins = w;
    it.rnd = RND_W'($urandom_range(0, 255));
    instr_q.push_back(it);
  endfunction

  // Random word nudged toward the encodings that the unit decodes
  function automatic logic [INS_W-1:0] rand_instr();
    logic [INS_W-1:0] w;
    w = INS_W'($urandom_range(0, 65535));
    case (w[15:12])
      OP_SYS: begin
        case ($urandom_range(0, 3))
          0: w = INS_CLS;
          1, 2: w = INS_RET;
          default: ;
        endcase
      end
      OP_SER, OP_SNER: if ($urandom_range(0, 3) != 0) w[3:0] = 4'h0;
      OP_ALU: begin
        case ($urandom_range(0, 9))
          0: w[3:0] = ALU_MOV;
          1: w[3:0] = ALU_OR;
          2: w[3:0] = ALU_AND;
          3: w[3:0] = ALU_XOR;
          4: w[3:0] = ALU_ADD;
          5: w[3:0] = ALU_SUB;
          6: w[3:0] = ALU_SHR;
          7: w[3:0] = ALU_SUBN;
          8: w[3:0] = ALU_SHL;
          default: ;
        endcase
      end
      OP_KEY: begin
        case ($urandom_range(0, 2))
          0: w[7:0] = KEY_SKP;
          1: w[7:0] = KEY_SKNP;
          default: ;
        endcase
      end
      OP_MISC: begin
        case ($urandom_range(0, 10))
          0: w[7:0] = F_LD_DT;
          1: w[7:0] = F_LD_K;
          2: w[7:0] = F_SET_DT;
          3: w[7:0] = F_SET_ST;
          4: w[7:0] = F_ADD_I;
          5: w[7:0] = F_FONT;
          6: w[7:0] = F_BCD;
          7: w[7:0] = F_STORE;
          8: w[7:0] = F_LOAD;
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // Queue random sequences: call chains, load-and-compare skips, single ops, noise
  task automatic queue_random(int count);
    int         queued;
    int         k;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] nn;
    queued = 0;
    while (queued < count) begin
      x = 4'($urandom_range(0, 15));
      y = 4'($urandom_range(0, 15));
      nn = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1: begin
          k = $urandom_range(1, 20);
          repeat (k) add_instr({OP_CALL, 12'($urandom_range(0, 4095))});
          repeat (k + $urandom_range(0, 2)) add_instr(INS_RET);
          queued += 2 * k;
        end
        2, 3: begin
          add_instr(enc_xnn(OP_LDI, x, nn));
          add_instr(enc_xnn(OP_LDI, y, $urandom_range(0, 1) ? nn : 8'($urandom_range(0, 255))));
          case ($urandom_range(0, 3))
            0: add_instr(enc_xnn(OP_SEI, x, $urandom_range(0, 1) ? nn : ~nn));
            1: add_instr(enc_xnn(OP_SNEI, x, $urandom_range(0, 1) ? nn : ~nn));
            2: add_instr(enc_xyn(OP_SER, x, y, 4'h0));
            default: add_instr(enc_xyn(OP_SNER, x, y, 4'h0));
          endcase
          queued += 3;
        end
        4: begin
          add_instr(INS_W'($urandom_range(0, 65535)));
          queued++;
        end
        default: begin
          add_instr(rand_instr());
          queued++;
        end
      endcase
    end
  endtask

  // Hold until every queued item is sent and every result has come back
  task automatic wait_drained();
    while (instr_q.size() != 0 || in_tvalid || exec_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_address(logic [PC_W-1:0] addr_val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= START_ADDR_OFS;
    cfg_pwdata <= CFG_DW'(addr_val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    pc_reg = addr_val;
  endtask

  task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Driver: present items from the queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        exec_result_q.push_back(execute_instr(in_tdata[15:0], in_tdata[23:16]));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (instr_q.size() != 0) begin
          send_item = instr_q.pop_front();
          in_tdata <= {send_item.rnd, send_item.ins};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result item against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (exec_result_q.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected: expected nothing, actual 0x%0h",
                   $time, out_tdata);
        end else begin
          automatic exec_res_t want = exec_result_q.pop_front();
          check_field("next_pc", want.next_pc, out_tdata[11:0]);
          check_field("status", 12'(want.status), 12'(out_tdata[14:12]));
          check_field("reg_written", 12'(want.reg_written), 12'(out_tdata[15]));
          check_field("reg_index", 12'(want.reg_index), 12'(out_tdata[19:16]));
          check_field("reg_value", 12'(want.reg_value), 12'(out_tdata[27:20]));
          check_field("flag_written", 12'(want.flag_written), 12'(out_tdata[28]));
          check_field("flag_value", 12'(want.flag_value), 12'(out_tdata[29]));
          check_field("index_value", want.index_value, out_tdata[41:30]);
          check_field("padding", 12'h000, 12'(out_tdata[47:42]));
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 5);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < REG_CNT; r++) v_reg[r] = '0;
    for (int s = 0; s < STACK_DEPTH_DEF; s++) call_stack[s] = '0;
    i_reg = '0;
    pc_reg = START_RESET;
    call_depth = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: system words, every ALU op, carries, skips, jumps, stack underflow
    add_instr(INS_RET);
    add_instr(INS_CLS);
    add_instr({OP_SYS, 12'h123});
    add_instr(enc_xnn(OP_LDI, 4'h0, 8'hFF));
    add_instr(enc_xnn(OP_LDI, 4'h1, 8'h01));
    add_instr(enc_xyn(OP_ALU, 4'h2, 4'h0, ALU_ADD));
    add_instr(enc_xnn(OP_ADDI, 4'h0, 8'hFF));
    add_instr(enc_xyn(OP_ALU, 4'h3, 4'h1, ALU_SUB));
    add_instr(enc_xyn(OP_ALU, 4'h4, 4'h0, ALU_SUBN));
    add_instr(enc_xyn(OP_ALU, 4'h5, 4'h0, ALU_SHR));
    add_instr(enc_xnn(OP_LDI, 4'h6, 8'h80));
    add_instr(enc_xyn(OP_ALU, 4'h7, 4'h6, ALU_SHL));
    add_instr(enc_xyn(OP_ALU, 4'h8, 4'h6, ALU_OR));
    add_instr(enc_xyn(OP_ALU, 4'h8, 4'h0, ALU_AND));
    add_instr(enc_xyn(OP_ALU, 4'h9, 4'h6, ALU_XOR));
    add_instr(enc_xyn(OP_ALU, 4'hA, 4'h6, ALU_MOV));
    add_instr(enc_xyn(OP_ALU, FLAG_REG, 4'h0, ALU_ADD));
    add_instr(enc_xyn(OP_ALU, 4'h1, 4'h1, ALU_UNUSED));
    add_instr(enc_xnn(OP_SEI, 4'h6, 8'h80));
    add_instr(enc_xnn(OP_SNEI, 4'h6, 8'h80));
    add_instr(enc_xyn(OP_SER, 4'h6, 4'hA, 4'h0));
    add_instr(enc_xyn(OP_SNER, 4'h6, 4'hA, 4'h0));
    add_instr(enc_xyn(OP_SER, 4'h6, 4'hA, 4'h1));
    add_instr({OP_JP, 12'hFFF});
    add_instr({OP_CALL, 12'h000});
    add_instr(INS_RET);
    add_instr({OP_LDIX, 12'hFFF});
    add_instr({OP_JPV0, 12'hFFF});
    add_instr(enc_xnn(OP_RND, 4'h4, 8'hFF));
    add_instr({OP_DRW, 12'h123});
    add_instr(enc_xnn(OP_KEY, 4'h2, KEY_SKP));
    add_instr(enc_xnn(OP_KEY, 4'h2, 8'h00));
    add_instr(enc_xnn(OP_MISC, 4'h3, F_BCD));
    add_instr(enc_xnn(OP_MISC, 4'hF, 8'hFF));
    queue_random(100);
    wait_drained();

    // Later phases restart from other program counters, extremes first
    write_start_address(12'hFFF);
    queue_random(100);
    wait_drained();
    write_start_address(12'h000);
    queue_random(100);
    wait_drained();
    write_start_address(PC_W'($urandom_range(1, 4094)));
    queue_random(100);
    wait_drained();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/c8x_pkg.sv
hw/rtl/c8x_regfile.sv
hw/rtl/c8x_stack.sv
hw/rtl/c8x_exec.sv
hw/rtl/chip8_register_execute_unit.sv
sim/tb_chip8_register_execute_unit.sv
